// File: hw/rtl/bitmap_frame_allocator_top_assert.svh
// Assertion macros of the bitmap frame allocator RTL.
// Needs no other file; included by bfa_engine, the module that checks itself.
`ifndef BITMAP_FRAME_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/bfa_pkg.sv
// Package of the bitmap frame allocator: field widths, operation and
// register codes, and the structs passed between its modules. No dependencies.
`default_nettype none

package bfa_pkg;

    localparam int FRAME_TOTAL_DEF = 4096;
    localparam int WORD_BITS_DEF   = 64;

    // Frames examined per cycle by the allocation scan.
    localparam int SLICE_BITS = 8;

    localparam int OP_W    = 2;
    localparam int FRAME_W = 12;
    localparam int CNT_W   = 13;
    localparam int REG_W   = 13;
    localparam int POS_W   = 14;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK  = 2'd2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FIRST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIMIT = 2'd1;

    localparam logic [REG_W-1:0] RANGE_FIRST_RST = 13'd0;
    localparam logic [REG_W-1:0] RANGE_LIMIT_RST = 13'd4096;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [FRAME_W-1:0] run_start;
        logic [CNT_W-1:0]   frame_count;
    } bfa_req_t;

    typedef struct packed {
        logic               status;
        logic [FRAME_W-1:0] frame_number;
    } bfa_rsp_t;

    typedef struct packed {
        logic               hit;
        logic               fail;
        logic               word_end;
        logic [CNT_W-1:0]   run;
        logic [POS_W-1:0]   hit_pos;
    } bfa_scan_t;

endpackage

`default_nettype wire

// File: hw/rtl/bfa_scan_slice.sv
// One allocation scan step: walks up to SLICE_BITS frames of a map word,
// tracking the free run length. Depends on bfa_pkg.
`default_nettype none

module bfa_scan_slice
    import bfa_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic [WORD_BITS-1:0]         word_data,
    input  wire logic [$clog2(WORD_BITS)-1:0] bit_off,
    input  wire logic [POS_W-1:0]             pos,
    input  wire logic [POS_W-1:0]             limit,
    input  wire logic [CNT_W-1:0]             count,
    input  wire logic [CNT_W-1:0]             run_in,
    output bfa_scan_t                         res
);

    localparam int BW = $clog2(WORD_BITS);

    always_comb begin
        logic             stop;
        logic [CNT_W-1:0] run;
        logic [BW:0]      b;
        logic [POS_W-1:0] f;
        res  = '0;
        stop = 1'b0;
        run  = run_in;
        for (int k = 0; k < SLICE_BITS; k++) begin
            b = {1'b0, bit_off} + (BW+1)'(k);
            f = pos + POS_W'(k);
            if (!stop) begin
                if (b >= (BW+1)'(WORD_BITS)) begin
                    stop = 1'b1;
                end else if (f >= limit) begin
                    res.fail = 1'b1;
                    stop     = 1'b1;
                end else if (word_data[b[BW-1:0]]) begin
                    run = '0;
                end else begin
                    run = run + CNT_W'(1);
                    if (run == count) begin
                        res.hit     = 1'b1;
                        res.hit_pos = f;
                        stop        = 1'b1;
                    end
                end
            end
        end
        res.run      = run;
        res.word_end = ({1'b0, bit_off} + (BW+1)'(SLICE_BITS)) >= (BW+1)'(WORD_BITS);
    end

endmodule

`default_nettype wire

// File: hw/rtl/bfa_engine.sv
// Sequencer of the bitmap frame allocator: owns the bitmap memory, clears it
// after reset, runs allocation scans and run writes. Depends on bfa_pkg,
// bfa_scan_slice and the assertion macro header.
`default_nettype none
`include "bitmap_frame_allocator_top_assert.svh"

module bfa_engine
    import bfa_pkg::*;
#(
    parameter int FRAME_TOTAL = FRAME_TOTAL_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire bfa_req_t         req,
    input  wire logic [REG_W-1:0] range_first,
    input  wire logic [REG_W-1:0] range_limit,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output bfa_rsp_t              rsp
);

    localparam int MAP_WORDS = (FRAME_TOTAL + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    // Frames that can ever be touched: the map, clipped to what the
    // 13-bit range and count fields can reach.
    localparam int CAP       = (FRAME_TOTAL < 8192) ? FRAME_TOTAL : 8192;
    // Word index by reciprocal multiply; exact for positions below 2**POS_W.
    localparam int RECIP_SH  = 21;
    localparam int RECIP     = ((1 << RECIP_SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int RECIP_W   = $clog2(RECIP + 1);
    localparam int PROD_W    = POS_W + RECIP_W;

    localparam logic [POS_W-1:0]   CAP_POS   = POS_W'(CAP);
    localparam logic [POS_W-1:0]   WB_POS    = POS_W'(WORD_BITS);
    localparam logic [RECIP_W-1:0] RECIP_V   = RECIP_W'(RECIP);
    localparam logic [AW-1:0]      LAST_WORD = AW'(MAP_WORDS - 1);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_DIV1  = 4'd2;
    localparam logic [3:0] ST_DIV2  = 4'd3;
    localparam logic [3:0] ST_SRD   = 4'd4;
    localparam logic [3:0] ST_SCAN  = 4'd5;
    localparam logic [3:0] ST_BASE  = 4'd6;
    localparam logic [3:0] ST_WRD   = 4'd7;
    localparam logic [3:0] ST_WMOD  = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] end_reg, end_next;
    logic [POS_W-1:0] q_reg, q_next;
    logic [POS_W-1:0] word_base_reg, word_base_next;
    logic [BW-1:0]    bit_off_reg, bit_off_next;
    logic [AW-1:0]    word_idx_reg, word_idx_next;
    logic [CNT_W-1:0] run_reg, run_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             alloc_reg, alloc_next;
    logic             set_reg, set_next;
    bfa_rsp_t         rsp_reg, rsp_next;

    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 mem_we;
    logic                 mem_re;
    logic [WORD_BITS-1:0] mem_wdata;

    logic [POS_W-1:0]     limit_eff;
    logic [PROD_W-1:0]    prod;
    logic [POS_W-1:0]     q_times_wb;
    logic [POS_W-1:0]     run_end;
    logic [POS_W-1:0]     base_pos;
    logic [POS_W-1:0]     hi_raw;
    logic [POS_W-1:0]     hi;
    logic [WORD_BITS-1:0] wr_mask;
    bfa_scan_t            scan_res;

    logic                 mem_acc;
    logic                 req_acc;
    logic                 scan_ok;

    assign limit_eff  = (POS_W'(range_limit) < CAP_POS) ? POS_W'(range_limit) : CAP_POS;
    assign prod       = PROD_W'(pos_reg) * PROD_W'(RECIP_V);
    assign q_times_wb = POS_W'(q_reg * WB_POS);
    assign run_end    = pos_reg + POS_W'(count_reg);
    assign base_pos   = pos_reg + POS_W'(1) - POS_W'(count_reg);
    assign hi_raw     = end_reg - word_base_reg;
    assign hi         = (hi_raw >= WB_POS) ? WB_POS : hi_raw;
    assign rsp        = rsp_reg;

    // Bits of the current word that fall inside the run being written.
    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            wr_mask[j] = ((BW+1)'(j) >= {1'b0, bit_off_reg}) && (POS_W'(j) < hi);
        end
    end

    bfa_scan_slice #(
        .WORD_BITS (WORD_BITS)
    ) u_scan (
        .word_data (rdata_reg),
        .bit_off   (bit_off_reg),
        .pos       (pos_reg),
        .limit     (limit_eff),
        .count     (count_reg),
        .run_in    (run_reg),
        .res       (scan_res)
    );

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        end_next       = end_reg;
        q_next         = q_reg;
        word_base_next = word_base_reg;
        bit_off_next   = bit_off_reg;
        word_idx_next  = word_idx_reg;
        run_next       = run_reg;
        count_next     = count_reg;
        alloc_next     = alloc_reg;
        set_next       = set_reg;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_wdata      = '0;
        req_ready      = 1'b0;
        rsp_valid      = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (word_idx_reg == LAST_WORD) begin
                    word_idx_next = '0;
                    state_next    = ST_IDLE;
                end else begin
                    word_idx_next = word_idx_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    count_next = req.frame_count;
                    alloc_next = (req.operation == OP_ALLOC);
                    set_next   = (req.operation != OP_FREE);
                    rsp_next   = '0;
                    pos_next   = (req.operation == OP_ALLOC) ? POS_W'(range_first)
                                                             : POS_W'(req.run_start);
                    unique case (req.operation) inside
                        OP_ALLOC: begin
                            if (req.frame_count == '0) begin
                                rsp_next.frame_number = range_first[FRAME_W-1:0];
                                state_next            = ST_DONE;
                            end else begin
                                state_next = ST_DIV1;
                            end
                        end
                        OP_FREE, OP_MARK: begin
                            state_next = ST_DIV1;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DIV1: begin
                q_next     = POS_W'(prod[PROD_W-1:RECIP_SH]);
                end_next   = (run_end < CAP_POS) ? run_end : CAP_POS;
                state_next = ST_DIV2;
            end
            ST_DIV2: begin
                word_base_next = q_times_wb;
                bit_off_next   = BW'(pos_reg - q_times_wb);
                word_idx_next  = AW'(q_reg);
                run_next       = '0;
                if (alloc_reg) begin
                    state_next = ST_SRD;
                end else if (pos_reg >= end_reg) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_WRD;
                end
            end
            ST_SRD: begin
                if (pos_reg >= limit_eff) begin
                    rsp_next.status = 1'b1;
                    state_next      = ST_DONE;
                end else begin
                    mem_re     = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                run_next = scan_res.run;
                if (scan_res.fail) begin
                    rsp_next.status = 1'b1;
                    state_next      = ST_DONE;
                end else if (scan_res.hit) begin
                    pos_next   = scan_res.hit_pos;
                    state_next = ST_BASE;
                end else if (scan_res.word_end) begin
                    word_base_next = word_base_reg + WB_POS;
                    pos_next       = word_base_reg + WB_POS;
                    bit_off_next   = '0;
                    word_idx_next  = word_idx_reg + AW'(1);
                    state_next     = ST_SRD;
                end else begin
                    pos_next     = pos_reg + POS_W'(SLICE_BITS);
                    bit_off_next = bit_off_reg + BW'(SLICE_BITS);
                end
            end
            ST_BASE: begin
                pos_next              = base_pos;
                rsp_next.frame_number = base_pos[FRAME_W-1:0];
                alloc_next            = 1'b0;
                state_next            = ST_DIV1;
            end
            ST_WRD: begin
                mem_re     = 1'b1;
                state_next = ST_WMOD;
            end
            ST_WMOD: begin
                mem_we         = 1'b1;
                mem_wdata      = set_reg ? (rdata_reg | wr_mask) : (rdata_reg & ~wr_mask);
                word_base_next = word_base_reg + WB_POS;
                word_idx_next  = word_idx_reg + AW'(1);
                bit_off_next   = '0;
                if ((word_base_reg + WB_POS) >= end_reg) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_WRD;
                end
            end
            ST_DONE: begin
                rsp_valid = 1'b1;
                if (rsp_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            word_idx_reg <= '0;
        end else begin
            state_reg    <= state_next;
            word_idx_reg <= word_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg       <= pos_next;
        end_reg       <= end_next;
        q_reg         <= q_next;
        word_base_reg <= word_base_next;
        bit_off_reg   <= bit_off_next;
        run_reg       <= run_next;
        count_reg     <= count_next;
        alloc_reg     <= alloc_next;
        set_reg       <= set_next;
        rsp_reg       <= rsp_next;
    end

    // Bitmap memory: one write and one registered read port, same address.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[word_idx_reg] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= map_mem[word_idx_reg];
        end
    end

    assign mem_acc = mem_we || mem_re;
    assign req_acc = req_valid && req_ready;
    assign scan_ok = (run_reg < count_reg) && (pos_reg <= limit_eff);

    `BFA_ASSERT_IMP(a_rw_excl, aclk, aresetn, mem_we, !mem_re, "map read and write overlap")
    `BFA_ASSERT_IMP(a_addr_in_map, aclk, aresetn, mem_acc, word_idx_reg <= LAST_WORD, "bad addr")
    `BFA_ASSERT_IMP(a_scan_bounds, aclk, aresetn, state_reg == ST_SCAN, scan_ok, "scan bounds")
    `BFA_ASSERT_NEXT(a_busy_next, aclk, aresetn, req_acc, state_reg != ST_IDLE, "idle after accept")

endmodule

`default_nettype wire

// File: hw/rtl/bitmap_frame_allocator_top.sv
// Top level of the bitmap frame allocator: configuration registers, result
// register and the sequencer. Depends on bfa_pkg and bfa_engine.
//
//  Channel  Direction  Handshake              Payload
//  s_       in         s_valid / s_ready      s_operation, s_run_start, s_frame_count
//  m_       out        m_valid / m_ready      m_status, m_frame_number
//  cfg_wr_  in         cfg_wr_en (no wait)    cfg_wr_index, cfg_wr_data
//
// After reset the bitmap is swept to zero, one map word per cycle, over all
// MAP_WORDS words (64 at the default size); no request is accepted meanwhile.
// An allocate first sets up its start word, then for each map word scanned
// makes one memory read and scan steps of SLICE_BITS frames each; the run
// found is then marked by reading and writing back each word it covers.
// A free or mark sets up its start word, then reads each map word touched
// and writes it back modified. A zero-length allocate or an unknown
// operation goes straight to the result. One request is worked at a time;
// the next is accepted once the previous result sits in the output register,
// and a stalled m_ready holds the sequencer only once that register is full.
`default_nettype none

module bitmap_frame_allocator_top
    import bfa_pkg::*;
#(
    parameter int FRAME_TOTAL = FRAME_TOTAL_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [OP_W-1:0]      s_operation,
    input  wire logic [FRAME_W-1:0]   s_run_start,
    input  wire logic [CNT_W-1:0]     s_frame_count,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_status,
    output logic [FRAME_W-1:0]        m_frame_number,

    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [REG_W-1:0]     cfg_wr_data
);

    // Allocation range; software must write it only while idle (not enforced).
    logic [REG_W-1:0] range_first_reg, range_first_next;
    logic [REG_W-1:0] range_limit_reg, range_limit_next;

    // Output register: parts the sequencer from the result channel.
    logic             m_valid_reg, m_valid_next;
    bfa_rsp_t         m_rsp_reg, m_rsp_next;

    bfa_req_t         req;
    bfa_rsp_t         rsp;
    logic             rsp_valid;
    logic             rsp_ready;

    assign req.operation   = s_operation;
    assign req.run_start   = s_run_start;
    assign req.frame_count = s_frame_count;

    // The sequencer may hand over a result when the output register is
    // empty or is being emptied in this same cycle.
    assign rsp_ready = !m_valid_reg || m_ready;

    bfa_engine #(
        .FRAME_TOTAL (FRAME_TOTAL),
        .WORD_BITS   (WORD_BITS)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_valid),
        .req_ready   (s_ready),
        .req         (req),
        .range_first (range_first_reg),
        .range_limit (range_limit_reg),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp)
    );

    // Register writes; indexes beyond the two registers are dropped.
    always_comb begin
        range_first_next = range_first_reg;
        range_limit_next = range_limit_reg;
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_RANGE_FIRST: begin
                    range_first_next = cfg_wr_data;
                end
                CFG_RANGE_LIMIT: begin
                    range_limit_next = cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_rsp_next   = m_rsp_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (rsp_valid && rsp_ready) begin
            m_valid_next = 1'b1;
            m_rsp_next   = rsp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_first_reg <= RANGE_FIRST_RST;
            range_limit_reg <= RANGE_LIMIT_RST;
            m_valid_reg     <= 1'b0;
        end else begin
            range_first_reg <= range_first_next;
            range_limit_reg <= range_limit_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_rsp_reg <= m_rsp_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_rsp_reg.status;
    assign m_frame_number = m_rsp_reg.frame_number;

endmodule

`default_nettype wire
